### hdl/sbda_pkg.sv
// Package: constants and the pipeline word shared by the decimal ASCII converter.
`default_nettype none
package sbda_pkg;

  // Field geometry.
  localparam int MAG_W           = 32;
  localparam int MIN_W           = 4;
  localparam int DIGIT_W         = 4;
  localparam int FIELD_LEN       = 10;
  localparam int BCD_W           = FIELD_LEN * DIGIT_W;
  localparam int CHAR_W          = 6;
  localparam int COUNT_W         = 4;

  // Double-dabble split: bits shifted per pipeline stage.
  localparam int STEPS_PER_STAGE = 8;
  localparam int DABBLE_STAGES   = MAG_W / STEPS_PER_STAGE;

  // Character codes, truncated to six bits.
  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;

  // Digit constants used by the add-3 correction and the minimum clamp.
  localparam logic [DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
  localparam logic [DIGIT_W-1:0] DABBLE_ADD   = 4'd3;
  localparam logic [COUNT_W-1:0] MAX_DIGITS   = 4'd10;

  // One item in flight through the converter.
  typedef struct packed {
    logic               neg;
    logic [MIN_W-1:0]   min_digits;
    logic [BCD_W-1:0]   bcd;
    logic [MAG_W-1:0]   bin;
  } sbda_work_t;

endpackage
`default_nettype wire

### hdl/sbda_in_if.sv
// Interface: input channel carrying the signed value and the minimum digit count.
`default_nettype none
interface sbda_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [sbda_pkg::MAG_W-1:0] value;
  logic [sbda_pkg::MIN_W-1:0]        min_digits;

  modport source (output valid, output value, output min_digits, input ready);
  modport sink   (input valid, input value, input min_digits, output ready);
endinterface
`default_nettype wire

### hdl/sbda_out_if.sv
// Interface: output channel carrying the ten ASCII characters of one field.
`default_nettype none
interface sbda_out_if;
  logic                        valid;
  logic                        ready;
  logic [sbda_pkg::CHAR_W-1:0] char_0;
  logic [sbda_pkg::CHAR_W-1:0] char_1;
  logic [sbda_pkg::CHAR_W-1:0] char_2;
  logic [sbda_pkg::CHAR_W-1:0] char_3;
  logic [sbda_pkg::CHAR_W-1:0] char_4;
  logic [sbda_pkg::CHAR_W-1:0] char_5;
  logic [sbda_pkg::CHAR_W-1:0] char_6;
  logic [sbda_pkg::CHAR_W-1:0] char_7;
  logic [sbda_pkg::CHAR_W-1:0] char_8;
  logic [sbda_pkg::CHAR_W-1:0] char_9;

  modport source (output valid, output char_0, output char_1, output char_2,
                  output char_3, output char_4, output char_5, output char_6,
                  output char_7, output char_8, output char_9, input ready);
  modport sink   (input valid, input char_0, input char_1, input char_2,
                  input char_3, input char_4, input char_5, input char_6,
                  input char_7, input char_8, input char_9, output ready);
endinterface
`default_nettype wire

### hdl/sbda_dabble.sv
// Module: one double-dabble pipeline stage that shifts several binary bits into BCD.
`default_nettype none
module sbda_dabble (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sbda_pkg::sbda_work_t in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sbda_pkg::sbda_work_t     out_data
);
  import sbda_pkg::*;

  sbda_work_t data;
  sbda_work_t data_next;
  logic       vld;

  // Add-3 correction on every digit of five or more, then a one-bit shift, repeated per step.
  always_comb begin
    logic [BCD_W-1:0] bcd;
    logic [MAG_W-1:0] bin;
    bcd = in_data.bcd;
    bin = in_data.bin;
    for (int s = 0; s < STEPS_PER_STAGE; s++) begin
      for (int d = 0; d < FIELD_LEN; d++) begin
        if (bcd[d*DIGIT_W +: DIGIT_W] >= DABBLE_LIMIT) begin
          bcd[d*DIGIT_W +: DIGIT_W] = bcd[d*DIGIT_W +: DIGIT_W] + DABBLE_ADD;
        end
      end
      bcd = {bcd[BCD_W-2:0], bin[MAG_W-1]};
      bin = {bin[MAG_W-2:0], 1'b0};
    end
    data_next            = in_data;
    data_next.bcd        = bcd;
    data_next.bin        = bin;
  end

  // The stage takes an item whenever it is empty or its item moves on.
  assign in_ready = !vld || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data <= data_next;
    end
  end

  assign out_valid = vld;
  assign out_data  = data;
endmodule
`default_nettype wire

### hdl/sbda_format.sv
// Module: builds the right-aligned ASCII field from the BCD digits and drives the output register.
`default_nettype none
module sbda_format (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sbda_pkg::sbda_work_t in_data,
  sbda_out_if.source               dout
);
  import sbda_pkg::*;

  logic [CHAR_W-1:0]  chars      [FIELD_LEN];
  logic [CHAR_W-1:0]  chars_next [FIELD_LEN];
  logic [COUNT_W-1:0] sig_digits;
  logic [COUNT_W-1:0] min_eff;
  logic [COUNT_W-1:0] shown;
  logic               vld;

  // Count of significant digits; zero still shows one digit.
  always_comb begin
    sig_digits = COUNT_W'(1);
    for (int j = 1; j < FIELD_LEN; j++) begin
      if (in_data.bcd[j*DIGIT_W +: DIGIT_W] != '0) begin
        sig_digits = COUNT_W'(j + 1);
      end
    end
  end

  // Digits shown: the larger of the significant count and the clamped minimum.
  assign min_eff = (in_data.min_digits > MAX_DIGITS) ? MAX_DIGITS : in_data.min_digits;
  assign shown   = (min_eff > sig_digits) ? min_eff : sig_digits;

  // Position j counts from the right: digit, then the sign if room is left, then spaces.
  always_comb begin
    for (int j = 0; j < FIELD_LEN; j++) begin
      if (COUNT_W'(j) < shown) begin
        chars_next[FIELD_LEN-1-j] = CH_ZERO
                                    + {2'b00, in_data.bcd[j*DIGIT_W +: DIGIT_W]};
      end else if (COUNT_W'(j) == shown && in_data.neg) begin
        chars_next[FIELD_LEN-1-j] = CH_MINUS;
      end else begin
        chars_next[FIELD_LEN-1-j] = CH_SPACE;
      end
    end
  end

  // Output register; a waiting result does not block a new item once taken.
  assign in_ready = !vld || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_ready) begin
      vld <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      chars <= chars_next;
    end
  end

  assign dout.valid  = vld;
  assign dout.char_0 = chars[0];
  assign dout.char_1 = chars[1];
  assign dout.char_2 = chars[2];
  assign dout.char_3 = chars[3];
  assign dout.char_4 = chars[4];
  assign dout.char_5 = chars[5];
  assign dout.char_6 = chars[6];
  assign dout.char_7 = chars[7];
  assign dout.char_8 = chars[8];
  assign dout.char_9 = chars[9];
endmodule
`default_nettype wire

### hdl/signed_binary_to_decimal_ascii.sv
// Top level: pipelined signed binary to right-aligned decimal ASCII converter.
//
//   Channel  Modport  Payload                         Accepted when
//   din      sink     value[31:0] s, min_digits[3:0]  din.valid && din.ready
//   dout     source   char_0 .. char_9, 6 bits each   dout.valid && dout.ready
//
// One item is accepted per cycle while dout does not stall; its result passes the entry
// register, each double-dabble stage and the output register on its way to dout.
// The stages are: sign and magnitude, four double-dabble stages of eight bits
// each, and the formatting stage that holds the output register.
// Reset clears only the valid bit of each stage.
// A stall at dout holds each full stage whose successor is also held; empty stages
// still fill, so no item is lost or repeated.
`default_nettype none
module signed_binary_to_decimal_ascii (
  input  wire logic  clk,
  input  wire logic  rst,
  sbda_in_if.sink    din,
  sbda_out_if.source dout
);
  import sbda_pkg::*;

  sbda_work_t entry;
  sbda_work_t entry_next;
  logic       entry_vld;
  logic       entry_ready;

  sbda_work_t stage_data  [DABBLE_STAGES+1];
  logic       stage_valid [DABBLE_STAGES+1];
  logic       stage_ready [DABBLE_STAGES+1];

  // Sign and magnitude; the most negative value wraps to 2147483648 unsigned.
  always_comb begin
    entry_next.neg        = din.value[MAG_W-1];
    entry_next.min_digits = din.min_digits;
    entry_next.bcd        = '0;
    entry_next.bin        = din.value[MAG_W-1] ? (~din.value + MAG_W'(1)) : din.value;
  end

  assign entry_ready = !entry_vld || stage_ready[0];
  assign din.ready   = entry_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= 1'b0;
    end else if (entry_ready) begin
      entry_vld <= din.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (din.valid && entry_ready) begin
      entry <= entry_next;
    end
  end

  assign stage_data[0]  = entry;
  assign stage_valid[0] = entry_vld;

  // Double-dabble chain.
  for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
    sbda_dabble u_dabble (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[g]),
      .in_ready  (stage_ready[g]),
      .in_data   (stage_data[g]),
      .out_valid (stage_valid[g+1]),
      .out_ready (stage_ready[g+1]),
      .out_data  (stage_data[g+1])
    );
  end

  // Character formatting and output register.
  sbda_format u_format (
    .clk      (clk),
    .rst      (rst),
    .in_valid (stage_valid[DABBLE_STAGES]),
    .in_ready (stage_ready[DABBLE_STAGES]),
    .in_data  (stage_data[DABBLE_STAGES]),
    .dout     (dout)
  );
endmodule
`default_nettype wire

### verif/tb_signed_binary_to_decimal_ascii.sv
// Testbench: checks the signed binary to decimal ASCII converter against its own predictor.
`timescale 1ns / 100ps
module tb_signed_binary_to_decimal_ascii;
  import sbda_pkg::*;

  // Ten characters of one field; index 0 is the leftmost character.
  typedef logic [FIELD_LEN-1:0][CHAR_W-1:0] ascii_field_t;

  // One conversion waiting for its result.
  typedef struct {
    logic [MAG_W-1:0] value;
    logic [MIN_W-1:0] min_digits;
    ascii_field_t     chars;
  } pending_conv_t;

  // One directed row; an empty text means the predictor supplies the field.
  typedef struct {
    logic [MAG_W-1:0] value;
    logic [MIN_W-1:0] min_digits;
    string            text;
  } directed_row_t;

  localparam int NUM_DIRECTED = 24;
  localparam int NUM_RANDOM   = 630;
  localparam int CALM_TAIL    = 100;
  localparam int DRAIN_CYCLES = 12;
  localparam int PRINT_CAP    = 60;

  logic clk;
  logic rst;

  sbda_in_if  din_bus ();
  sbda_out_if dout_bus ();

  pending_conv_t pending_convs[$];
  int            mismatch_count;
  bit            idling_on;
  ascii_field_t  seen_chars;
  pending_conv_t oldest_conv;

  signed_binary_to_decimal_ascii dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din_bus),
    .dout (dout_bus)
  );

  // Clock: 10 ns period.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Right-aligned decimal field: digits from the right, optional minus, then spaces.
  function automatic ascii_field_t format_decimal(input logic [MAG_W-1:0] raw,
                                                  input logic [MIN_W-1:0] min_digits);
    logic             neg;
    logic [MAG_W-1:0] mag;
    int               pos;
    int               need;
    ascii_field_t     field;
    neg  = raw[MAG_W-1];
    mag  = neg ? (~raw + 1'b1) : raw;
    pos  = FIELD_LEN;
    need = min_digits;
    while (pos != 0) begin
      pos--;
      field[pos] = CH_ZERO + CHAR_W'(mag % 10);
      mag = mag / 10;
      if (need != 0) need--;
      if (mag == 0 && need == 0) break;
    end
    // The sign only fits when a position is still free.
    if (neg && pos != 0) begin
      pos--;
      field[pos] = CH_MINUS;
    end
    while (pos != 0) begin
      pos--;
      field[pos] = CH_SPACE;
    end
    return field;
  endfunction

  // Mismatch reporting: one line each, printing capped, counting not.
  task automatic report_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP) $display("%0t ERROR: %s", $realtime, what);
  endtask

  // Present one item and hold it until accepted; the expectation is queued on acceptance.
  task automatic drive_conversion(input logic [MAG_W-1:0] value,
                                  input logic [MIN_W-1:0] min_digits,
                                  input ascii_field_t chars);
    pending_conv_t conv;
    conv.value      = value;
    conv.min_digits = min_digits;
    conv.chars      = chars;
    din_bus.valid      <= 1'b1;
    din_bus.value      <= value;
    din_bus.min_digits <= min_digits;
    do @(posedge clk); while (!din_bus.ready);
    pending_convs.push_back(conv);
    // Random sender gap; valid stays high when the next item follows directly.
    if (idling_on && $urandom_range(0, 3) == 0) begin
      din_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
  endtask

  // Receiver: ready in random stretches, with stall bursts while idling is on.
  initial begin
    dout_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (idling_on && $urandom_range(0, 3) == 0) begin
        dout_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk);
      end else begin
        dout_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Result checker: every accepted result against the oldest pending conversion.
  always @(posedge clk) begin
    if (!rst && dout_bus.valid && dout_bus.ready) begin
      seen_chars[0] = dout_bus.char_0;
      seen_chars[1] = dout_bus.char_1;
      seen_chars[2] = dout_bus.char_2;
      seen_chars[3] = dout_bus.char_3;
      seen_chars[4] = dout_bus.char_4;
      seen_chars[5] = dout_bus.char_5;
      seen_chars[6] = dout_bus.char_6;
      seen_chars[7] = dout_bus.char_7;
      seen_chars[8] = dout_bus.char_8;
      seen_chars[9] = dout_bus.char_9;
      if (pending_convs.size() == 0) begin
        report_mismatch("result arrived with no conversion pending");
      end else begin
        oldest_conv = pending_convs.pop_front();
        for (int k = 0; k < FIELD_LEN; k++) begin
          if (seen_chars[k] !== oldest_conv.chars[k])
            report_mismatch($sformatf("value %0d min %0d: char_%0d is %0d, expected %0d",
                                      $signed(oldest_conv.value), oldest_conv.min_digits,
                                      k, seen_chars[k], oldest_conv.chars[k]));
        end
      end
    end
  end

  // Watchdog for a hung handshake.
  initial begin
    #2_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Stimulus: reset, directed rows, random conversions, drain.
  initial begin
    directed_row_t    directed_rows [NUM_DIRECTED];
    ascii_field_t     chars;
    logic [MAG_W-1:0] value;
    logic [MIN_W-1:0] min_digits;
    int unsigned      power;

    mismatch_count     = 0;
    idling_on          = 1'b1;
    rst                <= 1'b1;
    din_bus.valid      <= 1'b0;
    din_bus.value      <= '0;
    din_bus.min_digits <= '0;

    directed_rows = '{
      '{32'd0,              4'd0,  "         0"},
      '{32'd0,              4'd15, "0000000000"},
      '{32'd2147483647,     4'd0,  "2147483647"},
      '{32'h8000_0000,      4'd0,  "2147483648"},
      '{32'h8000_0000,      4'd15, "2147483648"},
      '{-32'sd1,            4'd0,  "        -1"},
      '{-32'sd5,            4'd10, "0000000005"},
      '{-32'sd5,            4'd9,  "-000000005"},
      '{32'd123,            4'd11, "0000000123"},
      '{-32'sd123,          4'd4,  "     -0123"},
      '{-32'sd999999999,    4'd0,  "-999999999"},
      '{-32'sd1000000000,   4'd0,  "1000000000"},
      '{32'd1,              4'd1,  ""},
      '{32'd10,             4'd1,  ""},
      '{32'd999999999,      4'd3,  ""},
      '{32'd1000000000,     4'd12, ""},
      '{32'h5555_5555,      4'd5,  ""},
      '{32'hAAAA_AAAA,      4'd10, ""},
      '{32'h8000_0001,      4'd13, ""},
      '{-32'sd42,           4'd14, ""},
      '{32'd7,              4'd2,  ""},
      '{32'd65536,          4'd6,  ""},
      '{-32'sd100,          4'd3,  ""},
      '{32'd9,              4'd8,  ""}
    };

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: typed fields where obvious, predictor elsewhere.
    foreach (directed_rows[r]) begin
      if (directed_rows[r].text.len() == FIELD_LEN) begin
        for (int k = 0; k < FIELD_LEN; k++)
          chars[k] = CHAR_W'(directed_rows[r].text[k]);
      end else begin
        chars = format_decimal(directed_rows[r].value, directed_rows[r].min_digits);
      end
      drive_conversion(directed_rows[r].value, directed_rows[r].min_digits, chars);
    end

    // Random conversions, biased toward short numbers and decade boundaries.
    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM - CALM_TAIL) idling_on = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: value = $urandom;
        4, 5: begin
          value = $urandom_range(0, 999);
          if ($urandom_range(0, 1) == 1) value = -value;
        end
        6, 7, 8: begin
          power = 1;
          repeat ($urandom_range(0, 9)) power = power * 10;
          value = power - $urandom_range(0, 1);
          if ($urandom_range(0, 1) == 1) value = -value;
        end
        default: begin
          case ($urandom_range(0, 4))
            0:       value = 32'd0;
            1:       value = 32'hFFFF_FFFF;
            2:       value = 32'h7FFF_FFFF;
            3:       value = 32'h8000_0000;
            default: value = 32'h8000_0001;
          endcase
        end
      endcase
      min_digits = MIN_W'($urandom_range(0, 15));
      drive_conversion(value, min_digits, format_decimal(value, min_digits));
    end
    din_bus.valid <= 1'b0;

    // Drain, then allow a few more cycles for any stray result.
    while (pending_convs.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && pending_convs.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### files.f
hdl/sbda_pkg.sv
hdl/sbda_in_if.sv
hdl/sbda_out_if.sv
hdl/sbda_dabble.sv
hdl/sbda_format.sv
hdl/signed_binary_to_decimal_ascii.sv
verif/tb_signed_binary_to_decimal_ascii.sv
